>>> rtl/core/amacc_pkg.sv
// Shared types and constants for the angular moment accumulator.
// Used by amacc_root, angular_moment_accumulator and amacc_moment_checker; no dependencies.

package amacc_pkg;

    // Number of moment accumulators: energy, flux x/y, pressure xx/xy/yy
    localparam int NUM_MOM = 6;

    // Moments that are signed on the output (flux x, flux y, pressure xy)
    localparam logic [NUM_MOM-1:0] SIGNED_MOM = 6'b010110;

    // 1/(2*pi) in Q0.32, split into two 15-bit halves: K = HI * 2^15 + LO
    localparam logic [14:0] INV_2PI_HI = 15'd20860;
    localparam logic [14:0] INV_2PI_LO = 15'd24796;

    // Output clamp limits, as magnitudes
    localparam logic [47:0] U48_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] S48_MAG_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] S48_MAG_NEG = 48'h8000_0000_0000;

    // Saturation bounds of the 64-bit accumulators
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    // Root bits produced by the square root unit, one per cycle
    localparam int ROOT_STEPS = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMPLE,
        S_SCALE,
        S_NORM,
        S_ROOT
    } amacc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } amacc_root_stat_t;

endpackage

>>> rtl/core/amacc_root.sv
// Bit-serial integer square root, one root bit per cycle (restoring form).
// Depends on amacc_pkg for the step count and the status struct.

module amacc_root
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [95:0]                 radicand,
    output logic [47:0]                 root,
    output amacc_pkg::amacc_root_stat_t stat
);

    logic [95:0] rad_reg;
    logic [49:0] rem_reg;
    logic [47:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;

    logic [51:0] rem_sh;
    logic [51:0] trial;
    logic        fits;
    logic        last_step;

    assign rem_sh    = {rem_reg, rad_reg[95:94]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = (rem_sh >= trial);
    assign last_step = (cnt_reg == 6'(amacc_pkg::ROOT_STEPS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            // bring down two radicand bits, try the next root bit
            rad_reg <= {rad_reg[93:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= 50'(rem_sh - trial);
                root_reg <= {root_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[49:0];
                root_reg <= {root_reg[46:0], 1'b0};
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("root unit busy and done together");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == 6'd0)
        else $error("root unit did not start");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && last_step) |=> done_reg && !busy_reg)
        else $error("root unit did not finish after last step");

endmodule

>>> rtl/core/angular_moment_accumulator.sv
// Angular moment accumulator: top level with sequencer, shared multiplier,
// moment accumulators and output register. Depends on amacc_pkg, amacc_root.
//
// One direction item is accepted in the idle state; then seven steps run
// its six products through the single shared 37x17 multiplier and add
// each term into its saturating accumulator. An item marked last then
// scales the six sums by 1/(2*pi) (four partial products each on the
// same multiplier), forms the squares of the two flux components, and
// takes the bit-serial square root of the flux magnitude. The input is
// not ready while an item is in work. The finished result sits in an
// output register, so the next cell may start while it waits to be taken.

module angular_moment_accumulator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // intensity[31:0], weight[47:32], dir_x[63:48], dir_y[79:64]
    input  logic [79:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // energy[47:0], flux_x[95:48], flux_y[143:96], press_xx[191:144],
    // press_xy[239:192], press_yy[287:240], flux_norm[335:288]
    output logic [335:0] m_axis_tdata
);

    localparam int NM = amacc_pkg::NUM_MOM;

    amacc_pkg::amacc_state_t state_reg;
    amacc_pkg::amacc_state_t state_next;
    logic [3:0]  sub_reg;
    logic [3:0]  sub_next;
    logic [2:0]  ch_reg;
    logic [2:0]  ch_next;

    // latched item
    logic [31:0]        inten_reg;
    logic [15:0]        weight_reg;
    logic signed [15:0] dx_reg;
    logic signed [15:0] dy_reg;
    logic               last_reg;

    logic signed [63:0] acc_reg [NM];
    logic signed [63:0] acc_next [NM];

    logic signed [36:0] e_reg;
    logic signed [36:0] fx_reg;
    logic signed [36:0] fy_reg;

    // shared multiplier
    logic signed [36:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [53:0] mul_p;
    logic [5:0]         mul_sh;
    logic               mul_wide;
    logic signed [53:0] prod_reg;
    logic [5:0]         sh_reg;
    logic               wadd_reg;

    logic [95:0] wacc_reg;
    logic [63:0] mag_reg;
    logic        neg_reg;

    logic [47:0] res_reg [NM];
    logic [47:0] nx_reg;
    logic [47:0] ny_reg;
    logic [47:0] out_reg [NM];
    logic [47:0] out_norm_reg;
    logic        m_valid_reg;
    logic        m_valid_next;

    logic               accept;
    logic               root_start;
    logic               load_out;
    logic [47:0]        root_val;
    amacc_pkg::amacc_root_stat_t root_stat;

    logic signed [53:0] term_full;
    logic signed [36:0] term;
    logic [2:0]         acc_idx;
    logic signed [63:0] acc_sel;
    logic signed [64:0] sum65;
    logic signed [63:0] sat_sum;

    logic [61:0] q;
    logic [47:0] lim;
    logic [47:0] m_clamp;
    logic [47:0] res_val;

    logic [47:0] nv;
    logic [2:0]  nj;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amacc_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = amacc_pkg::S_SAMPLE;
            end
            amacc_pkg::S_SAMPLE:
            begin
                if (sub_reg == 4'd6)
                    state_next = last_reg ? amacc_pkg::S_SCALE : amacc_pkg::S_IDLE;
            end
            amacc_pkg::S_SCALE:
            begin
                if (sub_reg == 4'd6 && ch_reg == 3'(NM - 1))
                    state_next = amacc_pkg::S_NORM;
            end
            amacc_pkg::S_NORM:
            begin
                if (sub_reg == 4'd12)
                    state_next = amacc_pkg::S_ROOT;
            end
            amacc_pkg::S_ROOT:
            begin
                if (load_out)
                    state_next = amacc_pkg::S_IDLE;
            end
            default:
                state_next = amacc_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer outputs: counters, handshakes, multiplier operands
    // ---------------------------------------------------------------
    assign nv = (sub_reg < 4'd6) ? nx_reg : ny_reg;
    assign nj = (sub_reg < 4'd6) ? sub_reg[2:0] : 3'(sub_reg - 4'd6);

    always_comb
    begin
        sub_next      = sub_reg;
        ch_next       = ch_reg;
        s_axis_tready = 1'b0;
        root_start    = 1'b0;
        load_out      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        mul_sh        = '0;
        mul_wide      = 1'b0;
        unique case (state_reg)
            amacc_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                sub_next      = '0;
                ch_next       = '0;
            end
            amacc_pkg::S_SAMPLE:
            begin
                sub_next = (sub_reg == 4'd6) ? 4'd0 : sub_reg + 4'd1;
                case (sub_reg)
                    4'd0:
                    begin
                        mul_a = {5'b0, inten_reg};
                        mul_b = {1'b0, weight_reg};
                    end
                    4'd1:
                    begin
                        mul_a = term;
                        mul_b = 17'(dx_reg);
                    end
                    4'd2:
                    begin
                        mul_a = e_reg;
                        mul_b = 17'(dy_reg);
                    end
                    4'd3:
                    begin
                        mul_a = fx_reg;
                        mul_b = 17'(dx_reg);
                    end
                    4'd4:
                    begin
                        mul_a = fx_reg;
                        mul_b = 17'(dy_reg);
                    end
                    4'd5:
                    begin
                        mul_a = fy_reg;
                        mul_b = 17'(dy_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            amacc_pkg::S_SCALE:
            begin
                sub_next = (sub_reg == 4'd6) ? 4'd0 : sub_reg + 4'd1;
                if (sub_reg == 4'd6)
                    ch_next = (ch_reg == 3'(NM - 1)) ? 3'd0 : ch_reg + 3'd1;
                // magnitude times K in four 32x15 pieces
                case (sub_reg)
                    4'd1:
                    begin
                        mul_a    = {5'b0, mag_reg[31:0]};
                        mul_b    = {2'b0, amacc_pkg::INV_2PI_LO};
                        mul_sh   = 6'd0;
                        mul_wide = 1'b1;
                    end
                    4'd2:
                    begin
                        mul_a    = {5'b0, mag_reg[31:0]};
                        mul_b    = {2'b0, amacc_pkg::INV_2PI_HI};
                        mul_sh   = 6'd15;
                        mul_wide = 1'b1;
                    end
                    4'd3:
                    begin
                        mul_a    = {5'b0, mag_reg[63:32]};
                        mul_b    = {2'b0, amacc_pkg::INV_2PI_LO};
                        mul_sh   = 6'd32;
                        mul_wide = 1'b1;
                    end
                    4'd4:
                    begin
                        mul_a    = {5'b0, mag_reg[63:32]};
                        mul_b    = {2'b0, amacc_pkg::INV_2PI_HI};
                        mul_sh   = 6'd47;
                        mul_wide = 1'b1;
                    end
                    default:
                    begin
                        mul_wide = 1'b0;
                    end
                endcase
            end
            amacc_pkg::S_NORM:
            begin
                sub_next = (sub_reg == 4'd12) ? 4'd0 : sub_reg + 4'd1;
                // square as 24-bit halves times 16-bit thirds
                if (sub_reg < 4'd12)
                begin
                    mul_wide = 1'b1;
                    case (nj)
                        3'd0:
                        begin
                            mul_a  = {13'b0, nv[23:0]};
                            mul_b  = {1'b0, nv[15:0]};
                            mul_sh = 6'd0;
                        end
                        3'd1:
                        begin
                            mul_a  = {13'b0, nv[23:0]};
                            mul_b  = {1'b0, nv[31:16]};
                            mul_sh = 6'd16;
                        end
                        3'd2:
                        begin
                            mul_a  = {13'b0, nv[23:0]};
                            mul_b  = {1'b0, nv[47:32]};
                            mul_sh = 6'd32;
                        end
                        3'd3:
                        begin
                            mul_a  = {13'b0, nv[47:24]};
                            mul_b  = {1'b0, nv[15:0]};
                            mul_sh = 6'd24;
                        end
                        3'd4:
                        begin
                            mul_a  = {13'b0, nv[47:24]};
                            mul_b  = {1'b0, nv[31:16]};
                            mul_sh = 6'd40;
                        end
                        default:
                        begin
                            mul_a  = {13'b0, nv[47:24]};
                            mul_b  = {1'b0, nv[47:32]};
                            mul_sh = 6'd56;
                        end
                    endcase
                end
            end
            amacc_pkg::S_ROOT:
            begin
                if (sub_reg == 4'd0)
                begin
                    root_start = 1'b1;
                    sub_next   = 4'd1;
                end
                else if (root_stat.done && (!m_valid_reg || m_axis_tready))
                begin
                    load_out = 1'b1;
                    sub_next = 4'd0;
                end
            end
            default:
            begin
                sub_next = '0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;
    assign mul_p  = mul_a * mul_b;

    // ---------------------------------------------------------------
    // per-sample term and saturating accumulate
    // ---------------------------------------------------------------
    assign term_full = (sub_reg == 4'd1) ? (prod_reg >>> 13) : (prod_reg >>> 15);
    assign term      = term_full[36:0];
    assign acc_idx   = (state_reg == amacc_pkg::S_SAMPLE) ? 3'(sub_reg - 4'd1) : ch_reg;
    assign acc_sel   = acc_reg[acc_idx];
    assign sum65     = 65'(acc_sel) + 65'(term);

    always_comb
    begin
        if (sum65[64] != sum65[63])
            sat_sum = sum65[64] ? amacc_pkg::ACC_MIN : amacc_pkg::ACC_MAX;
        else
            sat_sum = sum65[63:0];
    end

    always_comb
    begin
        for (int i = 0; i < NM; i++)
            acc_next[i] = acc_reg[i];
        if (state_reg == amacc_pkg::S_SAMPLE && sub_reg != 4'd0)
            acc_next[acc_idx] = sat_sum;
        else if (state_reg == amacc_pkg::S_SCALE && sub_reg == 4'd6
                 && ch_reg == 3'(NM - 1))
        begin
            // cell done: clear for the next one
            for (int i = 0; i < NM; i++)
                acc_next[i] = '0;
        end
    end

    // ---------------------------------------------------------------
    // round, sign and clamp of one scaled moment
    // ---------------------------------------------------------------
    assign q = wacc_reg[93:32];

    always_comb
    begin
        lim     = neg_reg ? amacc_pkg::S48_MAG_NEG : amacc_pkg::S48_MAG_POS;
        m_clamp = (q > {14'b0, lim}) ? lim : q[47:0];
        if (amacc_pkg::SIGNED_MOM[ch_reg])
            res_val = neg_reg ? 48'(-m_clamp) : m_clamp;
        else if (neg_reg)
            res_val = '0;
        else
            res_val = (q > {14'b0, amacc_pkg::U48_MAX}) ? amacc_pkg::U48_MAX : q[47:0];
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_out)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= amacc_pkg::S_IDLE;
            sub_reg     <= '0;
            ch_reg      <= '0;
            wadd_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NM; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sub_reg     <= sub_next;
            ch_reg      <= ch_next;
            wadd_reg    <= mul_wide;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NM; i++)
                acc_reg[i] <= acc_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        sh_reg   <= mul_sh;

        if (accept)
        begin
            inten_reg  <= s_axis_tdata[31:0];
            weight_reg <= s_axis_tdata[47:32];
            dx_reg     <= s_axis_tdata[63:48];
            dy_reg     <= s_axis_tdata[79:64];
            last_reg   <= s_axis_tlast;
        end

        if (state_reg == amacc_pkg::S_SAMPLE)
        begin
            case (sub_reg)
                4'd1:    e_reg  <= term;
                4'd2:    fx_reg <= term;
                4'd3:    fy_reg <= term;
                default: e_reg  <= e_reg;
            endcase
        end

        if (state_reg == amacc_pkg::S_SCALE && sub_reg == 4'd0)
        begin
            neg_reg  <= acc_sel[63];
            mag_reg  <= acc_sel[63] ? 64'(-acc_sel) : acc_sel;
            wacc_reg <= 96'h8000_0000;
        end
        else if (state_reg == amacc_pkg::S_SCALE && sub_reg == 4'd6
                 && ch_reg == 3'(NM - 1))
            wacc_reg <= '0;
        else if (wadd_reg)
            wacc_reg <= wacc_reg + ({49'b0, prod_reg[46:0]} << sh_reg);

        if (state_reg == amacc_pkg::S_SCALE && sub_reg == 4'd6)
        begin
            res_reg[ch_reg] <= res_val;
            // keep flux magnitudes for the norm
            if (ch_reg == 3'd1)
                nx_reg <= m_clamp;
            if (ch_reg == 3'd2)
                ny_reg <= m_clamp;
        end

        if (load_out)
        begin
            for (int i = 0; i < NM; i++)
                out_reg[i] <= res_reg[i];
            out_norm_reg <= root_val;
        end
    end

    amacc_root u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (wacc_reg),
        .root     (root_val),
        .stat     (root_stat)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_norm_reg, out_reg[5], out_reg[4], out_reg[3],
                            out_reg[2], out_reg[1], out_reg[0]};

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_root_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        root_start |-> !root_stat.busy)
        else $error("root started while busy");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == amacc_pkg::S_SCALE && state_next == amacc_pkg::S_NORM)
        |=> (acc_reg[0] == 64'sd0 && acc_reg[NM-1] == 64'sd0))
        else $error("accumulators not cleared after a cell");

    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (root_val >= nx_reg && root_val >= ny_reg))
        else $error("flux norm below a flux component");

    a_wide_add_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wadd_reg |-> (state_reg == amacc_pkg::S_SCALE || state_reg == amacc_pkg::S_NORM))
        else $error("wide add outside scale or norm");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == amacc_pkg::S_SAMPLE && sub_reg == 4'd0))
        else $error("item accepted but sample sequence not started");

endmodule

>>> verif/amacc_moment_checker.sv
// Scoreboard for the angular moment accumulator: watches both stream channels,
// recomputes the six moments and the flux magnitude per cell, compares fields.
// Depends on amacc_pkg for the accumulator and output bounds.

module amacc_moment_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // intensity[31:0], weight[47:32], dir_x[63:48], dir_y[79:64]
    input  logic [79:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // energy, flux_x, flux_y, press_xx, press_xy, press_yy, flux_norm (48 bits each)
    input  logic [335:0] m_axis_tdata,
    output int           mismatches,
    output int           cells_pending
);

    // Last member lands in the lowest bits, matching the port layout
    typedef struct packed {
        logic [47:0] flux_norm;
        logic [47:0] press_yy;
        logic [47:0] press_xy;
        logic [47:0] press_xx;
        logic [47:0] flux_y;
        logic [47:0] flux_x;
        logic [47:0] energy;
    } cell_moments_t;

    typedef enum int {
        M_ENERGY,
        M_FLUX_X,
        M_FLUX_Y,
        M_PRESS_XX,
        M_PRESS_XY,
        M_PRESS_YY
    } moment_t;

    // round(2^32 / (2*pi))
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

    longint        moment_sum [amacc_pkg::NUM_MOM];
    cell_moments_t expected_cells_q [$];

    initial
    begin
        mismatches    = 0;
        cells_pending = 0;
    end

    function automatic longint sat_add(longint a, longint b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? amacc_pkg::ACC_MIN : amacc_pkg::ACC_MAX;
        return s[63:0];
    endfunction

    // Multiply by 1/(2*pi) in Q0.32, round half away from zero
    function automatic longint scale_moment(longint s);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (s < 0) ? -s : s;
        q = (mag >> 32) * INV_TWO_PI_Q32
            + ((mag[31:0] * INV_TWO_PI_Q32 + 64'h8000_0000) >> 32);
        return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_moment(longint v, bit sgn);
        longint lo;
        longint hi;
        lo = sgn ? -longint'(amacc_pkg::S48_MAG_NEG) : 64'sd0;
        hi = sgn ? longint'(amacc_pkg::S48_MAG_POS) : longint'(amacc_pkg::U48_MAX);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floor(sqrt(fx^2 + fy^2)), one root bit per step from the top
    function automatic logic [47:0] flux_magnitude(longint fx, longint fy);
        logic [63:0]  ax;
        logic [63:0]  ay;
        logic [127:0] norm_sq;
        logic [48:0]  root;
        logic [48:0]  trial;
        ax = (fx < 0) ? -fx : fx;
        ay = (fy < 0) ? -fy : fy;
        norm_sq = ax * ax + ay * ay;
        root = '0;
        for (int b = 48; b >= 0; b--)
        begin
            trial = root | (49'd1 << b);
            if (trial * trial <= norm_sq)
                root = trial;
        end
        return root[47:0];
    endfunction

    task automatic accumulate_direction(input logic [79:0] item, input logic lst);
        logic [47:0]        iw;
        logic signed [15:0] cx16;
        logic signed [15:0] cy16;
        longint             cx;
        longint             cy;
        longint             e;
        longint             fx;
        longint             fy;
        longint             term [amacc_pkg::NUM_MOM];
        longint             out_val [amacc_pkg::NUM_MOM];
        bit                 sgn;
        cell_moments_t      cm;
        iw   = item[31:0] * item[47:32];
        cx16 = item[63:48];
        cy16 = item[79:64];
        cx   = cx16;
        cy   = cy16;
        e    = iw >> 13;
        fx   = (e * cx) >>> 15;
        fy   = (e * cy) >>> 15;
        term[M_ENERGY]   = e;
        term[M_FLUX_X]   = fx;
        term[M_FLUX_Y]   = fy;
        term[M_PRESS_XX] = (fx * cx) >>> 15;
        term[M_PRESS_XY] = (fx * cy) >>> 15;
        term[M_PRESS_YY] = (fy * cy) >>> 15;
        foreach (moment_sum[m])
            moment_sum[m] = sat_add(moment_sum[m], term[m]);
        if (lst)
        begin
            foreach (moment_sum[m])
            begin
                sgn = (m == M_FLUX_X) || (m == M_FLUX_Y) || (m == M_PRESS_XY);
                out_val[m] = clamp_moment(scale_moment(moment_sum[m]), sgn);
                moment_sum[m] = 0;
            end
            cm.energy    = 48'(out_val[M_ENERGY]);
            cm.flux_x    = 48'(out_val[M_FLUX_X]);
            cm.flux_y    = 48'(out_val[M_FLUX_Y]);
            cm.press_xx  = 48'(out_val[M_PRESS_XX]);
            cm.press_xy  = 48'(out_val[M_PRESS_XY]);
            cm.press_yy  = 48'(out_val[M_PRESS_YY]);
            // magnitude comes from the already saturated flux components
            cm.flux_norm = flux_magnitude(out_val[M_FLUX_X], out_val[M_FLUX_Y]);
            expected_cells_q.push_back(cm);
        end
    endtask

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] got, input bit sgn);
        if (want !== got)
        begin
            mismatches++;
            if (sgn)
                $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            else
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cell_moments_t got;
        cell_moments_t want;
        if (!rst_n)
        begin
            foreach (moment_sum[m])
                moment_sum[m] = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                accumulate_direction(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_cells_q.size() == 0)
                begin
                    mismatches++;
                    $error("cell result with no cell pending: %h", m_axis_tdata);
                end
                else
                begin
                    want = expected_cells_q.pop_front();
                    compare_field("energy", want.energy, got.energy, 1'b0);
                    compare_field("flux_x", want.flux_x, got.flux_x, 1'b1);
                    compare_field("flux_y", want.flux_y, got.flux_y, 1'b1);
                    compare_field("press_xx", want.press_xx, got.press_xx, 1'b0);
                    compare_field("press_xy", want.press_xy, got.press_xy, 1'b1);
                    compare_field("press_yy", want.press_yy, got.press_yy, 1'b0);
                    compare_field("flux_norm", want.flux_norm, got.flux_norm, 1'b0);
                end
            end
        end
        cells_pending <= expected_cells_q.size();
    end

endmodule

>>> verif/angular_moment_accumulator_tb.sv
// Testbench top for angular_moment_accumulator: clock, reset, direction
// stimulus and output back-pressure; checking lives in amacc_moment_checker.
// Depends on amacc_pkg, the accumulator RTL and the checker.

module angular_moment_accumulator_tb;

    localparam int RANDOM_ITEMS     = 1300;
    localparam int QUIET_ITEMS      = 200;
    // long run of full-scale samples with a cosine of exactly -1
    localparam int SATURATION_ITEMS = 40;
    localparam int HOLD_AFTER_ITEMS = 400;
    localparam int HOLD_CYCLES      = 3000;
    localparam int DRAIN_CYCLES     = 160;
    localparam int CYCLE_LIMIT      = 3000000;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [335:0] m_axis_tdata;

    int mismatches;
    int cells_pending;
    int random_sent  = 0;
    int cycle_count  = 0;
    bit quiet        = 1'b0;
    bit sender_gaps  = 1'b1;

    always #5 clk = ~clk;

    angular_moment_accumulator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    amacc_moment_checker moment_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .cells_pending (cells_pending)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one direction item, optionally after a short gap, and hold it until taken
    task automatic send_direction(input logic [31:0] inten, input logic [15:0] w,
                                  input logic [15:0] dx, input logic [15:0] dy,
                                  input logic lst);
        int gap;
        gap = 0;
        if (sender_gaps && !quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {dy, dx, w, inten};
        s_axis_tlast  <= lst;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Output side: short random stalls, one long hold-off to fill the block
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && random_sent >= HOLD_AFTER_ITEMS)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && (cycle_count / 600) % 4 != 3 && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int          cell_len;
        logic [31:0] inten;
        logic [15:0] w;
        logic [15:0] dx;
        logic [15:0] dy;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-sample cells at the field extremes, some with cosines of exactly -1
        send_direction(32'h0, 16'h0, 16'h0, 16'h0, 1'b1);
        send_direction(32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1);
        send_direction(32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'h8000, 1'b1);
        send_direction(32'hFFFF_FFFF, 16'h0, 16'h7FFF, 16'h7FFF, 1'b1);
        send_direction(32'hFFFF_FFFF, 16'h0001, 16'h0, 16'h0, 1'b1);
        // Tiny negative term: floor rounding toward minus infinity
        send_direction(32'h0000_2000, 16'h0001, 16'hFFFF, 16'h0001, 1'b1);
        // Multi-sample cell with mixed signs
        send_direction(32'h0001_0000, 16'h2000, 16'h7FFF, 16'h0000, 1'b0);
        send_direction(32'h0001_0000, 16'h2000, 16'h8000, 16'h0000, 1'b0);
        send_direction(32'h0003_8000, 16'h1000, 16'h5A82, 16'hA57E, 1'b0);
        send_direction(32'h0000_0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b1);
        // Alternating bit patterns
        send_direction(32'hAAAA_AAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0);
        send_direction(32'h5555_5555, 16'h5555, 16'h5555, 16'hAAAA, 1'b1);

        // One long full-scale cell, sent back to back: large sums of both signs
        sender_gaps = 1'b0;
        for (int i = 0; i < SATURATION_ITEMS; i++)
            send_direction(32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'h7FFF,
                           i == SATURATION_ITEMS - 1);

        // Random cells, every one closed by a last sample
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       cell_len = 1;
                9:       cell_len = $urandom_range(20, 60);
                default: cell_len = $urandom_range(2, 10);
            endcase
            sender_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < cell_len; i++)
            begin
                quiet = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
                case ($urandom_range(0, 4))
                    0:       inten = $urandom_range(0, 1 << 20);
                    1:       inten = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
                    default: inten = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0:       w = 16'hFFFF;
                    1:       w = 16'h2000;
                    2:       w = 16'($urandom_range(0, 255));
                    default: w = 16'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       dx = 16'h8000;
                    1:       dx = 16'h7FFF;
                    2:       dx = 16'h0;
                    default: dx = 16'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       dy = 16'h8000;
                    1:       dy = 16'h7FFF;
                    2:       dy = 16'h0;
                    default: dy = 16'($urandom);
                endcase
                send_direction(inten, w, dx, dy, i == cell_len - 1);
                random_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (cells_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && cells_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/amacc_pkg.sv
rtl/core/amacc_root.sv
rtl/core/angular_moment_accumulator.sv
verif/amacc_moment_checker.sv
verif/angular_moment_accumulator_tb.sv
